### rtl/irlpe_pkg.sv
// ----------------------------------------------------------------------------
// irlpe_pkg
// Shared constants, codes and types of the line position estimator.
// ----------------------------------------------------------------------------
package irlpe_pkg;

    // Array size and derived widths.
    localparam int SENSOR_COUNT = 40;
    localparam int ADDR_W       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W        = ADDR_W + 1;

    // Field widths of the channels.
    localparam int IDX_W        = 6;
    localparam int SAMPLE_W     = 12;
    localparam int ERR_W        = 6;
    localparam int LIT_MASK_W   = 40;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Reset value of the lit threshold.
    localparam logic [SAMPLE_W-1:0] THR_RESET = 12'd2048;

    // Item function codes.
    typedef enum logic {
        OP_STORE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    // One entry of the queue between the front and the back.
    typedef struct packed {
        t_op                 op;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] sample;
    } t_queue_item;

    // Back sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_SEARCH,
        BK_SPAN,
        BK_DONE
    } t_back_state;

endpackage

### rtl/irlpe_if.sv
// ----------------------------------------------------------------------------
// irlpe_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface irlpe_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [irlpe_pkg::IDX_W-1:0]    sensor_index;
    logic [irlpe_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output func, output sensor_index, output sample,
                    input ready);
    modport sink   (input valid, input func, input sensor_index, input sample,
                    output ready);
endinterface

interface irlpe_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [irlpe_pkg::ERR_W-1:0] line_error;
    logic                             line_found;
    logic [irlpe_pkg::LIT_MASK_W-1:0] lit_mask;

    modport source (output valid, output line_error, output line_found,
                    output lit_mask, input ready);
    modport sink   (input valid, input line_error, input line_found,
                    input lit_mask, output ready);
endinterface

### rtl/irlpe_front.sv
// ----------------------------------------------------------------------------
// irlpe_front
// Accepts input beats, decodes the function, drops stores to sensors that
// do not exist and queues the remaining items for the back.
// ----------------------------------------------------------------------------
module irlpe_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    irlpe_in_if.sink               i_in,
    output logic                   o_q_valid,
    input  logic                   i_q_ready,
    output irlpe_pkg::t_queue_item o_q_item
);

    irlpe_pkg::t_queue_item          r_entry [irlpe_pkg::QUEUE_DEPTH];
    logic [irlpe_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [irlpe_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [irlpe_pkg::QPTR_W:0]      r_count;

    logic                            accept;
    logic                            keep;
    logic                            push;
    logic                            pop;
    irlpe_pkg::t_op                  op;
    irlpe_pkg::t_queue_item          item;

    // Decode the beat and decide whether it goes to the back.
    always_comb begin
        op          = irlpe_pkg::t_op'(i_in.func);
        keep        = (op == irlpe_pkg::OP_EVAL) ||
                      ({1'b0, i_in.sensor_index} <
                       (irlpe_pkg::IDX_W + 1)'(irlpe_pkg::SENSOR_COUNT));
        item.op     = op;
        item.addr   = i_in.sensor_index[irlpe_pkg::ADDR_W-1:0];
        item.sample = i_in.sample;
    end

    // No beat is taken while reset is held.
    assign i_in.ready = i_rst_n &&
                        (r_count != (irlpe_pkg::QPTR_W + 1)'(irlpe_pkg::QUEUE_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign push       = accept && keep;
    assign pop        = o_q_valid && i_q_ready;

    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_entry[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == irlpe_pkg::QPTR_W'(irlpe_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == irlpe_pkg::QPTR_W'(irlpe_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/irlpe_back.sv
// ----------------------------------------------------------------------------
// irlpe_back
// Holds the sample store and the threshold, streams the store through the
// smoothing window, searches the lit mask and drives the result register.
// ----------------------------------------------------------------------------
module irlpe_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [irlpe_pkg::SAMPLE_W-1:0]  i_cfg_data,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  irlpe_pkg::t_queue_item          i_q_item,
    irlpe_out_if.source                     o_out
);

    localparam int N      = irlpe_pkg::SENSOR_COUNT;
    localparam int AW     = irlpe_pkg::ADDR_W;
    localparam int CW     = irlpe_pkg::CNT_W;
    localparam int SW     = irlpe_pkg::SAMPLE_W;
    localparam int SUM_W  = SW + 2;
    localparam int EW     = (AW + 2 > irlpe_pkg::ERR_W) ? AW + 2 : irlpe_pkg::ERR_W;
    localparam logic [AW-1:0] LAST = AW'(N - 1);
    localparam logic [CW-1:0] CL   = CW'((N - 1) / 2);
    localparam logic [CW-1:0] CR   = CW'(N / 2);
    localparam logic [CW-1:0] LAST_C = CW'(N - 1);

    // Sample store, its written flags and the threshold.
    logic [SW-1:0]                  r_mem [N];
    logic [N-1:0]                   r_valid;
    logic [SW-1:0]                  r_thr;

    // Sequencer and streaming registers.
    irlpe_pkg::t_back_state         r_state, n_state;
    logic [AW-1:0]                  r_rd_addr, n_rd_addr;
    logic                           r_issuing, n_issuing;
    logic                           r_rd_pend;
    logic [AW-1:0]                  r_rd_idx;
    logic [SW-1:0]                  r_rd_data;
    logic                           r_rd_vld;
    logic [SW-1:0]                  r_win0;
    logic [SW-1:0]                  r_win1;
    logic [N-1:0]                   r_lit, n_lit;
    logic [CW-1:0]                  r_off, n_off;
    logic [AW-1:0]                  r_left, n_left;
    logic [AW-1:0]                  r_right, n_right;
    logic signed [irlpe_pkg::ERR_W-1:0] r_res_err, n_res_err;
    logic                           r_res_found, n_res_found;

    // Result register.
    logic                           r_out_valid;
    logic signed [irlpe_pkg::ERR_W-1:0] r_out_err;
    logic                           r_out_found;
    logic [irlpe_pkg::LIT_MASK_W-1:0] r_out_mask;

    logic                           mem_we;
    logic                           out_load;
    logic [SW-1:0]                  cur;
    logic [SUM_W-1:0]               sum2, sum3, thr2, thr3;
    logic                           end_lit;
    logic [CW-1:0]                  a_idx, b_idx;
    logic                           lit_a, lit_b;
    logic                           ext_l, ext_r;
    logic signed [EW-1:0]           span_sum, span_half;
    logic [irlpe_pkg::LIT_MASK_W-1:0] mask_full;

    // Window sums against the threshold: floor(s/3) > T is s >= 3T+3,
    // floor(s/2) > T is s >= 2T+2.
    always_comb begin
        cur  = r_rd_vld ? r_rd_data : '0;
        sum2 = SUM_W'(r_win0) + SUM_W'(cur);
        sum3 = sum2 + SUM_W'(r_win1);
        thr2 = SUM_W'({r_thr, 1'b0}) + SUM_W'(2);
        thr3 = SUM_W'({r_thr, 1'b0}) + SUM_W'(r_thr) + SUM_W'(3);
        end_lit = (N == 1) ? (cur > r_thr) : (sum2 >= thr2);
    end

    // Outward search probes, left side first.
    always_comb begin
        a_idx = CL - r_off;
        b_idx = CR + r_off;
        lit_a = (r_off <= CL) && r_lit[a_idx[AW-1:0]];
        lit_b = (b_idx <= LAST_C) && r_lit[b_idx[AW-1:0]];
    end

    // Span growth and the halved midpoint offset, truncated toward zero.
    always_comb begin
        ext_l     = (r_left != '0) && r_lit[r_left - 1'b1];
        ext_r     = (r_right != LAST) && r_lit[r_right + 1'b1];
        span_sum  = $signed(EW'(r_left)) + $signed(EW'(r_right)) - $signed(EW'(N - 1));
        span_half = (span_sum + $signed(EW'(span_sum[EW-1]))) >>> 1;
    end

    // Lit mask as seen on the result channel.
    for (genvar g = 0; g < irlpe_pkg::LIT_MASK_W; g++) begin : g_mask
        if (g < N) begin : g_on
            assign mask_full[g] = r_lit[g];
        end else begin : g_off
            assign mask_full[g] = 1'b0;
        end
    end

    assign o_q_ready = (r_state == irlpe_pkg::BK_IDLE);
    assign mem_we    = i_q_valid && o_q_ready && (i_q_item.op == irlpe_pkg::OP_STORE);
    assign out_load  = (r_state == irlpe_pkg::BK_DONE) && (!r_out_valid || o_out.ready);

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_rd_addr   = r_rd_addr;
        n_issuing   = r_issuing;
        n_lit       = r_lit;
        n_off       = r_off;
        n_left      = r_left;
        n_right     = r_right;
        n_res_err   = r_res_err;
        n_res_found = r_res_found;
        unique case (r_state)
            irlpe_pkg::BK_IDLE: begin
                if (i_q_valid && i_q_item.op == irlpe_pkg::OP_EVAL) begin
                    n_rd_addr = '0;
                    n_issuing = 1'b1;
                    n_state   = irlpe_pkg::BK_READ;
                end
            end
            irlpe_pkg::BK_READ: begin
                if (r_issuing) begin
                    if (r_rd_addr == LAST) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + 1'b1;
                    end
                end
                if (r_rd_pend) begin
                    // The arriving sample completes the window of its left neighbor.
                    if (r_rd_idx == AW'(1)) begin
                        n_lit[r_rd_idx - 1'b1] = (sum2 >= thr2);
                    end else if (r_rd_idx != '0) begin
                        n_lit[r_rd_idx - 1'b1] = (sum3 >= thr3);
                    end
                    if (r_rd_idx == LAST) begin
                        n_lit[LAST] = end_lit;
                        n_off       = '0;
                        n_state     = irlpe_pkg::BK_SEARCH;
                    end
                end
            end
            irlpe_pkg::BK_SEARCH: begin
                if (lit_a) begin
                    n_left  = a_idx[AW-1:0];
                    n_right = a_idx[AW-1:0];
                    n_state = irlpe_pkg::BK_SPAN;
                end else if (lit_b) begin
                    n_left  = b_idx[AW-1:0];
                    n_right = b_idx[AW-1:0];
                    n_state = irlpe_pkg::BK_SPAN;
                end else if (r_off == CR) begin
                    n_res_err   = '0;
                    n_res_found = 1'b0;
                    n_state     = irlpe_pkg::BK_DONE;
                end else begin
                    n_off = r_off + 1'b1;
                end
            end
            irlpe_pkg::BK_SPAN: begin
                if (ext_l) begin
                    n_left = r_left - 1'b1;
                end
                if (ext_r) begin
                    n_right = r_right + 1'b1;
                end
                if (!ext_l && !ext_r) begin
                    n_res_err   = span_half[irlpe_pkg::ERR_W-1:0];
                    n_res_found = 1'b1;
                    n_state     = irlpe_pkg::BK_DONE;
                end
            end
            irlpe_pkg::BK_DONE: begin
                if (out_load) begin
                    n_state = irlpe_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = irlpe_pkg::BK_IDLE;
            end
        endcase
    end

    // Sample store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_item.addr] <= i_q_item.sample;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= irlpe_pkg::BK_IDLE;
            r_issuing   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_valid     <= '0;
            r_thr       <= irlpe_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_rd_pend <= (r_state == irlpe_pkg::BK_READ) && r_issuing;
            if (mem_we) begin
                r_valid[i_q_item.addr] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_rd_idx    <= r_rd_addr;
        r_rd_vld    <= r_valid[r_rd_addr];
        r_lit       <= n_lit;
        r_off       <= n_off;
        r_left      <= n_left;
        r_right     <= n_right;
        r_res_err   <= n_res_err;
        r_res_found <= n_res_found;
        if (r_rd_pend) begin
            r_win1 <= r_win0;
            r_win0 <= cur;
        end
        if (out_load) begin
            r_out_err   <= r_res_err;
            r_out_found <= r_res_found;
            r_out_mask  <= mask_full;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.line_error = r_out_err;
    assign o_out.line_found = r_out_found;
    assign o_out.lit_mask   = r_out_mask;

    // Read data only arrives while the store is being streamed.
    a_pend_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == irlpe_pkg::BK_READ))
        else $error("read data arrived outside the streaming phase");

    // Reads are only issued while streaming.
    a_issue_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (r_state == irlpe_pkg::BK_READ))
        else $error("read issued outside the streaming phase");

    // A growing span stays ordered and both of its ends are lit.
    a_span_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == irlpe_pkg::BK_SPAN) |->
        ((r_left <= r_right) && r_lit[r_left] && r_lit[r_right]))
        else $error("span ends are not lit sensors");

    // A search that finds nothing has seen an empty lit mask.
    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == irlpe_pkg::BK_DONE) && !r_res_found) |-> (r_lit == '0))
        else $error("no line reported while a sensor is lit");

endmodule

### rtl/ir_line_position_estimator_unit.sv
// ----------------------------------------------------------------------------
// ir_line_position_estimator_unit
// Infrared line sensor position estimator: sample store, smoothing,
// threshold, outward line search and midpoint offset.
// ----------------------------------------------------------------------------
// Stores sustain one beat per cycle through the two-entry queue while the
// back is idle. An evaluate beat streams the sample store through its
// single read port, one sensor per cycle, to build the lit mask, then runs
// the outward search and span growth, one sensor per side each cycle, and
// loads the result register; a hit found further out can only grow away
// from the center. A result that waits on the output stalls the back and,
// once the queue is full, the input. The store reads as zero after reset
// through per-sensor written flags, so no clearing pass is needed. The
// threshold port must be written only while idle; the block itself does
// not enforce it.
// ----------------------------------------------------------------------------
module ir_line_position_estimator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [irlpe_pkg::SAMPLE_W-1:0]  i_cfg_data,
    irlpe_in_if.sink                        i_in,
    irlpe_out_if.source                     o_out
);

    logic                   q_valid;
    logic                   q_ready;
    irlpe_pkg::t_queue_item q_item;

    // Front: accept, classify and queue.
    irlpe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    // Back: store, evaluate and deliver.
    irlpe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_item   (q_item),
        .o_out      (o_out)
    );

endmodule

### tb/ir_line_position_estimator_unit_tb.sv
// ----------------------------------------------------------------------------
// ir_line_position_estimator_unit_tb
// Self-checking bench for the line position estimator. Sample stores and
// evaluate beats are sent through the input channel with random gaps. Every
// accepted beat updates a model of the sample store inside a small checker
// class. Each evaluate beat adds one predicted estimate, which is compared
// field by field with the result beats in order. The lit threshold is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module ir_line_position_estimator_unit_tb;
    import irlpe_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // One line estimate as carried by a result beat.
    typedef struct packed {
        logic [ERR_W-1:0]      line_error;
        logic                  line_found;
        logic [LIT_MASK_W-1:0] lit_mask;
    } t_line_estimate;

    // Keeps a copy of the sample store and the threshold, predicts the
    // estimate of every evaluate beat and checks the result beats in order.
    class t_line_estimate_board;
        logic [SAMPLE_W-1:0] raw_frame [SENSOR_COUNT];
        logic [SAMPLE_W-1:0] lit_threshold;
        t_line_estimate      expected_estimates [$];
        int                  mismatches;

        function new();
            foreach (raw_frame[i])
                raw_frame[i] = '0;
            lit_threshold = THR_RESET;
            mismatches    = 0;
        endfunction

        function void set_threshold(logic [SAMPLE_W-1:0] value);
            lit_threshold = value;
        endfunction

        function int outstanding();
            return expected_estimates.size();
        endfunction

        // Called for every accepted input beat.
        function void note_beat(t_op op, logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] smp);
            int             n;
            int             cl;
            int             cr;
            int             hit;
            int             lo;
            int             hi;
            int             offset;
            int unsigned    smooth;
            bit             lit [SENSOR_COUNT];
            t_line_estimate est;

            n = SENSOR_COUNT;
            if (op == OP_STORE) begin
                // Out-of-range indexes leave the store untouched.
                if (idx < n)
                    raw_frame[idx] = smp;
                return;
            end

            // Spatial smoothing and threshold compare.
            est = '0;
            for (int i = 0; i < n; i++) begin
                if (n == 1)
                    smooth = raw_frame[0];
                else if (i == 0)
                    smooth = (raw_frame[i] + raw_frame[i+1]) / 2;
                else if (i == n - 1)
                    smooth = (raw_frame[i-1] + raw_frame[i]) / 2;
                else
                    smooth = (raw_frame[i-1] + raw_frame[i] + raw_frame[i+1]) / 3;
                lit[i] = (smooth > lit_threshold);
                if (lit[i] && i < LIT_MASK_W)
                    est.lit_mask[i] = 1'b1;
            end

            // Search outward from the center, left side first at each distance.
            cl  = (n - 1) / 2;
            cr  = n / 2;
            hit = -1;
            for (int off = 0; off <= cr && hit < 0; off++) begin
                if (cl - off >= 0 && lit[cl-off])
                    hit = cl - off;
                else if (cr + off < n && lit[cr+off])
                    hit = cr + off;
            end

            // Widen the hit to its contiguous lit span and report its offset.
            if (hit >= 0) begin
                lo = hit;
                hi = hit;
                while (lo > 0 && lit[lo-1])
                    lo--;
                while (hi < n - 1 && lit[hi+1])
                    hi++;
                offset          = (lo + hi - (n - 1)) / 2;
                est.line_error  = offset[ERR_W-1:0];
                est.line_found  = 1'b1;
            end
            expected_estimates.push_back(est);
        endfunction

        // Called for every accepted result beat.
        function void check_estimate(logic [ERR_W-1:0] err, logic found,
                                     logic [LIT_MASK_W-1:0] mask);
            t_line_estimate want;

            if (expected_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected estimate: error=%0d found=%b mask=%h",
                             $signed(err), found, mask);
                return;
            end
            want = expected_estimates.pop_front();
            if (err !== want.line_error || found !== want.line_found ||
                mask !== want.lit_mask) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: estimate mismatch: expected error=%0d found=%b mask=%h,",
                             $signed(want.line_error), want.line_found, want.lit_mask,
                             " got error=%0d found=%b mask=%h",
                             $signed(err), found, mask);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [SAMPLE_W-1:0] i_cfg_data;

    irlpe_in_if  in_if ();
    irlpe_out_if out_if ();

    t_line_estimate_board board;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   quiet_cycles = 0;

    ir_line_position_estimator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Result side stalls at random.
    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Result checking and the watchdog on channel activity.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                board.check_estimate(out_if.line_error, out_if.line_found, out_if.lit_mask);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** ir_line_position_estimator_unit: FAILED **");
                $finish;
            end
        end
    end

    // Drive one input beat after a random gap and hold it until accepted.
    task automatic send_beat(t_op op, logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.func         <= op;
        in_if.sensor_index <= idx;
        in_if.sample       <= smp;
        do
            @(posedge i_clk);
        while (in_if.ready !== 1'b1);
        board.note_beat(op, idx, smp);
    endtask

    // Stop sending and wait for every outstanding estimate.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Change the threshold once the block has gone idle.
    task automatic write_threshold(logic [SAMPLE_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.set_threshold(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        @(posedge i_clk);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    // Mostly frames with one line blob on a darker floor, refreshed fully or
    // in part and then evaluated; the rest is unstructured noise.
    task automatic run_traffic(int beats);
        int  sent;
        int  center;
        int  width;
        int  level;
        int  floor_level;
        int  count;
        int  idx;
        int  gap;
        t_op op;

        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(0, 99) < 75) begin
                center      = $urandom_range(0, SENSOR_COUNT - 1);
                width       = $urandom_range(1, 8);
                level       = $urandom_range(2500, 4095);
                floor_level = $urandom_range(0, 1500);
                count       = ($urandom_range(0, 3) == 0) ? SENSOR_COUNT : $urandom_range(1, 10);
                for (int k = 0; k < count; k++) begin
                    idx = (count == SENSOR_COUNT) ? k : $urandom_range(0, SENSOR_COUNT - 1);
                    gap = (idx > center) ? idx - center : center - idx;
                    if (2 * gap < width)
                        send_beat(OP_STORE, IDX_W'(idx),
                                  SAMPLE_W'(level - $urandom_range(0, 300)));
                    else
                        send_beat(OP_STORE, IDX_W'(idx),
                                  SAMPLE_W'(floor_level + $urandom_range(0, 300)));
                    sent++;
                end
                send_beat(OP_EVAL, IDX_W'($urandom), SAMPLE_W'($urandom));
                sent++;
            end else begin
                op  = ($urandom_range(0, 1) == 1) ? OP_EVAL : OP_STORE;
                idx = $urandom_range(0, 63);
                send_beat(op, IDX_W'(idx), SAMPLE_W'($urandom));
                if (op == OP_EVAL || idx < SENSOR_COUNT)
                    sent++;
            end
            // Now and then let the block run completely dry.
            if ($urandom_range(0, 99) < 2)
                drain();
        end
    endtask

    initial begin
        board              = new();
        send_idle_pct      = 30;
        recv_idle_pct      = 74;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.func         = OP_STORE;
        in_if.sensor_index = '0;
        in_if.sample       = '0;
        out_if.ready       = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store under the reset threshold: no line.
        send_beat(OP_EVAL, '0, '0);
        // Full-scale lines at both ends; out-of-range stores are dropped.
        send_beat(OP_STORE, 6'd0, 12'hFFF);
        send_beat(OP_STORE, 6'd1, 12'hFFF);
        send_beat(OP_STORE, 6'd38, 12'hFFF);
        send_beat(OP_STORE, 6'd39, 12'hFFF);
        send_beat(OP_STORE, 6'd40, 12'hFFF);
        send_beat(OP_STORE, 6'd63, 12'hFFF);
        // Equal distance on both sides: the left span wins.
        send_beat(OP_EVAL, 6'd63, 12'hFFF);
        // A span across the center takes priority.
        send_beat(OP_STORE, 6'd19, 12'hFFF);
        send_beat(OP_STORE, 6'd20, 12'hFFF);
        send_beat(OP_EVAL, '0, '0);
        // Only the first sensor lit: negative offset truncates toward zero.
        send_beat(OP_STORE, 6'd1, 12'd2048);
        send_beat(OP_STORE, 6'd38, '0);
        send_beat(OP_STORE, 6'd39, '0);
        send_beat(OP_STORE, 6'd19, '0);
        send_beat(OP_STORE, 6'd20, '0);
        send_beat(OP_EVAL, '0, '0);

        // Lowest threshold: every neighborhood with a nonzero rounded-down mean is lit.
        write_threshold('0);
        send_beat(OP_EVAL, '0, '0);
        // Highest threshold: nothing can be lit, even at full scale.
        write_threshold(12'hFFF);
        send_beat(OP_STORE, 6'd5, 12'hFFF);
        send_beat(OP_STORE, 6'd6, 12'hFFF);
        send_beat(OP_STORE, 6'd7, 12'hFFF);
        send_beat(OP_EVAL, '0, '0);

        // Random traffic under three idling patterns and thresholds.
        write_threshold(SAMPLE_W'($urandom_range(1800, 2600)));
        set_idling(30, 74);
        run_traffic(360);
        write_threshold(SAMPLE_W'($urandom_range(1200, 3200)));
        set_idling(74, 30);
        run_traffic(360);
        write_threshold(SAMPLE_W'($urandom_range(1200, 3200)));
        set_idling(0, 0);
        run_traffic(380);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("** ir_line_position_estimator_unit: PASSED **");
        else
            $display("** ir_line_position_estimator_unit: FAILED **");
        $finish;
    end

endmodule

### ir_line_position_estimator_unit.f
rtl/irlpe_pkg.sv
rtl/irlpe_if.sv
rtl/irlpe_front.sv
rtl/irlpe_back.sv
rtl/ir_line_position_estimator_unit.sv
tb/ir_line_position_estimator_unit_tb.sv
